### design/assert_macros.svh
// assertion macros used by the checker file eafr_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### design/eafr_pkg.sv
// types and constants of the escaped api frame receiver
// no dependencies
package eafr_pkg;

	localparam int unsigned HEADER_BYTES = 3;

	localparam logic [2:0] EV_PAYLOAD   = 3'd0;
	localparam logic [2:0] EV_COMPLETE  = 3'd1;
	localparam logic [2:0] EV_DELIM_ERR = 3'd2;
	localparam logic [2:0] EV_LENH_ERR  = 3'd3;
	localparam logic [2:0] EV_LENL_ERR  = 3'd4;
	localparam logic [2:0] EV_RESTART   = 3'd5;

	localparam logic [1:0] REG_START_DELIM = 2'd0;
	localparam logic [1:0] REG_ESC_MARKER  = 2'd1;
	localparam logic [1:0] REG_ESC_MASK    = 2'd2;

	localparam logic [7:0] RST_START_DELIM = 8'h7e;
	localparam logic [7:0] RST_ESC_MARKER  = 8'h7d;
	localparam logic [7:0] RST_ESC_MASK    = 8'h20;

	typedef struct packed {
		logic [7:0] start_delimiter;
		logic [7:0] escape_marker;
		logic [7:0] escape_mask;
	} cfg_t;

	typedef struct packed {
		logic       has;
		logic [2:0] event_res;
		logic [7:0] data_byte;
		logic [7:0] byte_index;
		logic [7:0] frame_length;
	} result_t;

endpackage

### design/eafr_cfg.sv
// configuration registers of the frame receiver
// depends on eafr_pkg
module eafr_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_data,
	output eafr_pkg::cfg_t    cfg
);

	eafr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_delimiter <= eafr_pkg::RST_START_DELIM;
			cfg_q.escape_marker   <= eafr_pkg::RST_ESC_MARKER;
			cfg_q.escape_mask     <= eafr_pkg::RST_ESC_MASK;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				eafr_pkg::REG_START_DELIM: cfg_q.start_delimiter <= cfg_data;
				eafr_pkg::REG_ESC_MARKER:  cfg_q.escape_marker   <= cfg_data;
				eafr_pkg::REG_ESC_MASK:    cfg_q.escape_mask     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### design/eafr_core.sv
// deframing state and the per-byte decode logic
// depends on eafr_pkg
module eafr_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  eafr_pkg::cfg_t       cfg,
	input  logic                 step,
	input  logic [7:0]           rx_byte,
	output eafr_pkg::result_t    res
);

	logic [8:0] pos_q, pos_d;
	logic       esc_q, esc_d;
	logic [7:0] len_q, len_d;
	logic [8:0] end_pos;

	assign end_pos = {1'b0, len_q} + 9'(eafr_pkg::HEADER_BYTES);

	always_comb begin
		pos_d            = pos_q;
		esc_d            = esc_q;
		len_d            = len_q;
		res.has          = 1'b0;
		res.event_res    = eafr_pkg::EV_PAYLOAD;
		res.data_byte    = 8'd0;
		res.byte_index   = 8'd0;
		res.frame_length = 8'd0;
		priority if (pos_q == 9'd0) begin
			// hunting for the start delimiter
			if (rx_byte != cfg.start_delimiter) begin
				res.has       = 1'b1;
				res.event_res = eafr_pkg::EV_DELIM_ERR;
			end else begin
				pos_d = 9'd1;
			end
		end else if (pos_q == 9'd1) begin
			if (rx_byte != 8'd0) begin
				pos_d         = 9'd0;
				res.has       = 1'b1;
				res.event_res = eafr_pkg::EV_LENH_ERR;
			end else begin
				pos_d = 9'd2;
			end
		end else if (pos_q == 9'd2) begin
			if (!esc_q) begin
				if (rx_byte == cfg.escape_marker) begin
					esc_d = 1'b1;
				end else begin
					len_d = rx_byte;
					pos_d = 9'd3;
				end
			end else begin
				esc_d = 1'b0;
				if (rx_byte == cfg.escape_marker) begin
					pos_d         = 9'd0;
					res.has       = 1'b1;
					res.event_res = eafr_pkg::EV_LENL_ERR;
				end else begin
					len_d = rx_byte ^ cfg.escape_mask;
					pos_d = 9'd3;
				end
			end
		end else if (rx_byte == cfg.start_delimiter && !esc_q) begin
			// delimiter inside a frame restarts it
			pos_d            = 9'd1;
			len_d            = 8'd0;
			res.has          = 1'b1;
			res.event_res    = eafr_pkg::EV_RESTART;
			res.frame_length = len_q;
		end else if (!esc_q && rx_byte == cfg.escape_marker) begin
			esc_d = 1'b1;
		end else if (pos_q < end_pos) begin
			esc_d            = 1'b0;
			pos_d            = pos_q + 9'd1;
			res.has          = 1'b1;
			res.event_res    = eafr_pkg::EV_PAYLOAD;
			res.data_byte    = esc_q ? (rx_byte ^ cfg.escape_mask) : rx_byte;
			res.byte_index   = 8'(pos_q - 9'd2);
			res.frame_length = len_q;
		end else begin
			// checksum byte, not verified
			pos_d            = 9'd0;
			esc_d            = 1'b0;
			len_d            = 8'd0;
			res.has          = 1'b1;
			res.event_res    = eafr_pkg::EV_COMPLETE;
			res.frame_length = len_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 9'd0;
			esc_q <= 1'b0;
			len_q <= 8'd0;
		end else if (step) begin
			pos_q <= pos_d;
			esc_q <= esc_d;
			len_q <= len_d;
		end
	end

endmodule

### design/escaped_api_frame_receiver.sv
// escaped api frame receiver: input register, decode core, result register
// depends on eafr_pkg, eafr_cfg, eafr_core
//
// channel   direction  handshake           payload
// in        input      in_valid/in_stall   rx_byte
// out       output     out_valid/out_stall event_res, data_byte, byte_index, frame_length
// cfg       input      cfg_wr_en           cfg_index, cfg_data
//
// one byte per cycle sustained while out_stall is low; a result is offered after its byte
// passes the input register, the single decode pass in eafr_core and the result register
// arst_n clears the frame state, both valid flags and loads the register defaults
// a stalled result holds; a byte advances past the input register while a result
// waits only if it produces no result
module escaped_api_frame_receiver (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] event_res,
	output logic [7:0] data_byte,
	output logic [7:0] byte_index,
	output logic [7:0] frame_length,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	eafr_pkg::cfg_t    cfg;
	eafr_pkg::result_t res;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	logic [2:0] event_q;
	logic [7:0] data_q;
	logic [7:0] index_q;
	logic [7:0] length_q;
	logic       out_free;
	logic       adv;

	eafr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	eafr_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step    (adv),
		.rx_byte (byte_s1),
		.res     (res)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign adv      = valid_s1 && (!res.has || out_free);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res.has) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.has) begin
			event_q  <= res.event_res;
			data_q   <= res.data_byte;
			index_q  <= res.byte_index;
			length_q <= res.frame_length;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_res    = event_q;
	assign data_byte    = data_q;
	assign byte_index   = index_q;
	assign frame_length = length_q;

endmodule

### design/eafr_checker.sv
// port-level checks of the frame receiver, bound to the top level
// depends on assert_macros.svh, eafr_pkg
`include "assert_macros.svh"

module eafr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] event_res,
	input logic [7:0] data_byte,
	input logic [7:0] byte_index,
	input logic [7:0] frame_length
);

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable({event_res, data_byte, byte_index, frame_length}))
	`ASSERT_IMPL(a_event_range, clk, arst_n, out_valid, event_res <= eafr_pkg::EV_RESTART)
	`ASSERT_IMPL(a_nonpayload_zero, clk, arst_n, out_valid && event_res != eafr_pkg::EV_PAYLOAD, data_byte == 8'd0 && byte_index == 8'd0)
	`ASSERT_IMPL(a_payload_index, clk, arst_n, out_valid && event_res == eafr_pkg::EV_PAYLOAD, byte_index != 8'd0 && byte_index <= frame_length)
	`ASSERT_IMPL(a_error_no_length, clk, arst_n, out_valid && (event_res == eafr_pkg::EV_DELIM_ERR || event_res == eafr_pkg::EV_LENH_ERR || event_res == eafr_pkg::EV_LENL_ERR), frame_length == 8'd0)

endmodule

bind escaped_api_frame_receiver eafr_checker u_eafr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.event_res    (event_res),
	.data_byte    (data_byte),
	.byte_index   (byte_index),
	.frame_length (frame_length)
);
